// ===== src/bcf_pkg.sv =====
// Shared types, constants and microcode ROM for the binomial coefficient unit.
package bcf_pkg;

   localparam int ARG_W   = 6;
   localparam int VAL_W   = 63;
   localparam int I_W     = ARG_W + 1;
   localparam int PROD_W  = VAL_W + I_W;
   localparam int CNT_W   = $clog2(VAL_W);
   localparam int STEP_W  = 4;
   localparam int MAXN_W  = 8;
   localparam int DEF_MAX_N = 63;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_ORDER    = 2'd2;

   typedef struct packed {
      logic [ARG_W-1:0] n_total;
      logic [ARG_W-1:0] m_chosen;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] coefficient;
      logic [1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] num;
      logic [VAL_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
   } div_stat_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_CHECK,
      OP_INIT,
      OP_MUL,
      OP_SAVE_FN,
      OP_SAVE_FM,
      OP_DIV1,
      OP_DIV2,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_REQ,
      COND_BAD,
      COND_LOOP,
      COND_DIV,
      COND_OUT,
      COND_JUMP
   } cond_type;

   typedef enum logic [1:0] {
      TSEL_N,
      TSEL_M,
      TSEL_R
   } tsel_type;

   typedef struct packed {
      op_type             op;
      cond_type           cond;
      tsel_type           tsel;
      logic [STEP_W-1:0]  jump;
   } ucode_type;

   localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
   localparam logic [STEP_W-1:0] STEP_OUT  = 4'd14;

   function automatic ucode_type cw(op_type op, cond_type cond, tsel_type tsel,
                                    logic [STEP_W-1:0] jump);
      ucode_type w;
      w.op   = op;
      w.cond = cond;
      w.tsel = tsel;
      w.jump = jump;
      return w;
   endfunction

   // Microcode ROM: one control word per step.
   function automatic ucode_type ucode(logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         4'd0:  w = cw(OP_LOAD,    COND_REQ,  TSEL_N, STEP_WAIT);
         4'd1:  w = cw(OP_CHECK,   COND_BAD,  TSEL_N, STEP_OUT);
         4'd2:  w = cw(OP_INIT,    COND_NEXT, TSEL_N, STEP_WAIT);
         4'd3:  w = cw(OP_MUL,     COND_LOOP, TSEL_N, STEP_OUT);
         4'd4:  w = cw(OP_SAVE_FN, COND_NEXT, TSEL_N, STEP_WAIT);
         4'd5:  w = cw(OP_INIT,    COND_NEXT, TSEL_M, STEP_WAIT);
         4'd6:  w = cw(OP_MUL,     COND_LOOP, TSEL_M, STEP_OUT);
         4'd7:  w = cw(OP_SAVE_FM, COND_NEXT, TSEL_M, STEP_WAIT);
         4'd8:  w = cw(OP_INIT,    COND_NEXT, TSEL_R, STEP_WAIT);
         4'd9:  w = cw(OP_MUL,     COND_LOOP, TSEL_R, STEP_OUT);
         4'd10: w = cw(OP_DIV1,    COND_NEXT, TSEL_N, STEP_WAIT);
         4'd11: w = cw(OP_NOP,     COND_DIV,  TSEL_N, STEP_WAIT);
         4'd12: w = cw(OP_DIV2,    COND_NEXT, TSEL_N, STEP_WAIT);
         4'd13: w = cw(OP_NOP,     COND_DIV,  TSEL_N, STEP_WAIT);
         4'd14: w = cw(OP_OUT,     COND_OUT,  TSEL_N, STEP_WAIT);
         default: w = cw(OP_NOP,   COND_JUMP, TSEL_N, STEP_WAIT);
      endcase
      return w;
   endfunction

endpackage

// ===== src/bcf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bcf_div
   import bcf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  div_cmd_type      cmd,
   output div_stat_type     stat,
   output logic [VAL_W-1:0] quotient
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0] quo_ff, quo_in;
   logic [VAL_W-1:0] den_ff, den_in;
   logic [VAL_W:0]   shifted;
   logic [VAL_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[VAL_W-1]};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = cmd.num;
         den_in  = cmd.den;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[VAL_W-1:0];
            quo_in = {quo_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[VAL_W-1:0];
            quo_in = {quo_ff[VAL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VAL_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign quotient  = quo_ff;

endmodule

// ===== src/binomial_coefficient_by_factorials_unit.sv =====
// Binomial coefficient C(n,m) by factorials, run by a microcoded sequencer.
//
// Requests arrive on req_valid/req_data; req_stall is high whenever a
// request is in work, so one request is processed at a time. The result
// (coefficient and status) sits in an output register on rsp_valid/rsp_data
// until rsp_stall is low; the next request is taken while it waits.
// Each factorial of k takes a setup step, multiplies by i = 2 up to k in a
// 63x7 multiplier, and an exit step; n! and m! add a save step. The two
// divisions share a one-bit-per-cycle restoring divider.
// Bad argument order or n above MAX_N ends the request before any factorial;
// n! overflowing 63 bits ends it as soon as a product overflows.
// A stalled receiver holds the sequencer at its output step.
// Reset is synchronous: the sequencer returns to its wait step and the
// output register empties.
module binomial_coefficient_by_factorials_unit
   import bcf_pkg::*;
#(
   parameter int MAX_N = DEF_MAX_N
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [ARG_W-1:0]  n_ff, n_in;
   logic [ARG_W-1:0]  m_ff, m_in;
   logic [ARG_W-1:0]  target_ff, target_in;
   logic [I_W-1:0]    i_ff, i_in;
   logic [VAL_W-1:0]  acc_ff, acc_in;
   logic [VAL_W-1:0]  fn_ff, fn_in;
   logic [VAL_W-1:0]  fm_ff, fm_in;
   logic [1:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   ucode_type         uw;
   logic [PROD_W-1:0] prod;
   logic              mul_ovf;
   logic              loop_done;
   logic              bad_order;
   logic              bad_range;
   logic              out_free;
   logic [ARG_W-1:0]  target_sel;
   div_cmd_type       div_cmd;
   div_stat_type      div_stat;
   logic [VAL_W-1:0]  div_q;

   bcf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .stat     (div_stat),
      .quotient (div_q)
   );

   always_comb begin
      uw        = ucode(step_ff);
      prod      = {{I_W{1'b0}}, acc_ff} * {{VAL_W{1'b0}}, i_ff};
      mul_ovf   = |prod[PROD_W-1:VAL_W];
      loop_done = i_ff > {1'b0, target_ff};
      bad_order = m_ff > n_ff;
      bad_range = {{(MAXN_W-ARG_W){1'b0}}, n_ff} > MAXN_W'(MAX_N);
      out_free  = !rsp_valid_ff || !rsp_stall;
      case (uw.tsel)
         TSEL_N:  target_sel = n_ff;
         TSEL_M:  target_sel = m_ff;
         TSEL_R:  target_sel = n_ff - m_ff;
         default: target_sel = n_ff;
      endcase
   end

   // Sequencer: next step.
   always_comb begin
      step_in = step_ff;
      case (uw.cond)
         COND_NEXT: step_in = step_ff + 1'b1;
         COND_REQ: begin
            if (req_valid) step_in = step_ff + 1'b1;
         end
         COND_BAD: begin
            if (bad_order || bad_range) step_in = uw.jump;
            else                        step_in = step_ff + 1'b1;
         end
         COND_LOOP: begin
            if (loop_done)    step_in = step_ff + 1'b1;
            else if (mul_ovf) step_in = uw.jump;
         end
         COND_DIV: begin
            if (!div_stat.busy) step_in = step_ff + 1'b1;
         end
         COND_OUT: begin
            if (out_free) step_in = uw.jump;
         end
         COND_JUMP: step_in = uw.jump;
         default:   step_in = STEP_WAIT;
      endcase
   end

   // Datapath control from the current control word.
   always_comb begin
      n_in         = n_ff;
      m_in         = m_ff;
      target_in    = target_ff;
      i_in         = i_ff;
      acc_in       = acc_ff;
      fn_in        = fn_ff;
      fm_in        = fm_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_cmd      = '0;
      case (uw.op)
         OP_LOAD: begin
            if (req_valid) begin
               n_in      = req_data.n_total;
               m_in      = req_data.m_chosen;
               status_in = ST_OK;
            end
         end
         OP_CHECK: begin
            if (bad_order)      status_in = ST_ORDER;
            else if (bad_range) status_in = ST_OVERFLOW;
         end
         OP_INIT: begin
            acc_in    = VAL_W'(1);
            i_in      = I_W'(2);
            target_in = target_sel;
         end
         OP_MUL: begin
            if (!loop_done) begin
               if (mul_ovf) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  acc_in = prod[VAL_W-1:0];
                  i_in   = i_ff + 1'b1;
               end
            end
         end
         OP_SAVE_FN: fn_in = acc_ff;
         OP_SAVE_FM: fm_in = acc_ff;
         OP_DIV1: begin
            div_cmd.start = 1'b1;
            div_cmd.num   = fn_ff;
            div_cmd.den   = fm_ff;
         end
         OP_DIV2: begin
            div_cmd.start = 1'b1;
            div_cmd.num   = div_q;
            div_cmd.den   = acc_ff;
         end
         OP_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.coefficient = (status_ff == ST_OK) ? div_q : '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      m_ff        <= m_in;
      target_ff   <= target_in;
      i_ff        <= i_in;
      acc_ff      <= acc_in;
      fn_ff       <= fn_in;
      fm_ff       <= fm_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (step_ff != STEP_WAIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
